FILE: src/gn3_pkg.sv
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared types and constants for the 3-D gradient noise pipeline.
// ----------------------------------------------------------------------------
package gn3_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int HASH_W      = 8;
    localparam int FRAC_W      = 16;
    localparam int FADE_W      = FRAC_W + 1;
    localparam int VAL_W       = 20;
    localparam int OUT_W       = 18;

    typedef logic [HASH_W-1:0]       t_hash;
    typedef logic [FRAC_W-1:0]       t_frac;
    typedef logic [FADE_W-1:0]       t_fade;
    typedef logic signed [VAL_W-1:0] t_val;

    // fixed point one in Q16
    localparam t_val ONE_Q16 = 20'sd65536;
    // saturation limits of the result word
    localparam t_val OUT_MAX = 20'sd131071;
    localparam t_val OUT_MIN = -20'sd131072;

    // constant term of the fade inner factor, 10.0 in Q16
    localparam logic [20:0] FADE_TEN = 21'd655360;

endpackage

FILE: src/gn3_perm_ram.sv
// ----------------------------------------------------------------------------
// gn3_perm_ram
// One copy of the permutation table: one write port, two registered reads.
// ----------------------------------------------------------------------------
module gn3_perm_ram (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  gn3_pkg::t_hash i_waddr,
    input  gn3_pkg::t_hash i_wdata,
    input  gn3_pkg::t_hash i_raddr_a,
    input  gn3_pkg::t_hash i_raddr_b,
    output gn3_pkg::t_hash o_rdata_a,
    output gn3_pkg::t_hash o_rdata_b
);

    gn3_pkg::t_hash r_mem [gn3_pkg::TABLE_DEPTH];
    gn3_pkg::t_hash r_rdata_a;
    gn3_pkg::t_hash r_rdata_b;

    // table write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads, held while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: src/gn3_fade.sv
// ----------------------------------------------------------------------------
// gn3_fade
// Three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 in Q16.
// ----------------------------------------------------------------------------
module gn3_fade (
    input  logic           i_clk,
    input  logic           i_en,
    input  gn3_pkg::t_frac i_t,
    output gn3_pkg::t_fade o_fade
);

    gn3_pkg::t_frac r_t;
    gn3_pkg::t_frac r_t2;
    gn3_pkg::t_frac r_t3;
    logic [20:0]    r_inner;
    gn3_pkg::t_fade r_fade;
    logic [31:0]    w_sq;
    logic [31:0]    w_cu;
    logic [36:0]    w_prod;

    assign w_sq   = i_t * i_t;
    assign w_cu   = r_t2 * r_t;
    assign w_prod = r_t3 * r_inner;

    // stage a: square
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= i_t;
            r_t2 <= w_sq[31:16];
        end
    end

    // stage b: cube and inner factor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t3    <= w_cu[31:16];
            r_inner <= gn3_pkg::FADE_TEN + 21'(r_t2 * 6) - 21'(r_t * 15);
        end
    end

    // stage c: final product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fade <= w_prod[32:16];
        end
    end

    assign o_fade = r_fade;

endmodule

FILE: src/gradient_noise_3d_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d_top
// Improved 3-D gradient noise over a loadable permutation table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_ready carries one word per point or table
//   load. i_op = 0 writes i_table_value at i_table_index; i_op = 1 evaluates
//   noise at (i_point_x, i_point_y, i_point_z), signed fixed point with
//   FRAC_BITS fraction bits. Loads give no output word.
//   Output channel o_valid / i_ready carries o_noise_value in Q16.
//   Throughput: one word per cycle while the output is not stalled; the
//   three chained hash lookups read seven copies of the table (2, 4 and 8
//   read ports), and every load writes each copy as it passes that copy's
//   stage, so loads and points stay in order.
//   A stall on the output freezes the whole pipeline; o_ready falls while
//   a finished word waits and nothing is lost or repeated.
//   Reset empties the pipeline; the table contents are undefined until
//   loaded and are not cleared.
// ----------------------------------------------------------------------------
module gradient_noise_3d_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [17:0] o_noise_value
);

    typedef gn3_pkg::t_hash t_hash;
    typedef gn3_pkg::t_frac t_frac;
    typedef gn3_pkg::t_fade t_fade;
    typedef gn3_pkg::t_val  t_val;

    function automatic t_val grad(input t_hash h, input t_val x, input t_val y,
                                  input t_val z);
        logic [3:0] hl;
        t_val       u;
        t_val       v;
        begin
            hl = h[3:0];
            u  = (hl < 4'd8) ? x : y;
            v  = (hl < 4'd4) ? y : ((hl == 4'd12 || hl == 4'd14) ? x : z);
            grad = (hl[0] ? -u : u) + (hl[1] ? -v : v);
        end
    endfunction

    function automatic t_val lerp(input t_fade t, input t_val a, input t_val b);
        logic signed [20:0] d;
        logic signed [38:0] p;
        begin
            d    = {b[19], b} - {a[19], a};
            p    = $signed({1'b0, t}) * d;
            lerp = a + $signed(p[35:16]);
        end
    endfunction

    function automatic t_val off(input t_frac f, input logic far);
        t_val base;
        begin
            base = $signed({4'd0, f});
            off  = far ? base - gn3_pkg::ONE_Q16 : base;
        end
    endfunction

    // pipeline enable
    logic w_en;
    logic w_acc;
    logic r_ov;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;
    assign w_acc   = i_valid && w_en;

    // cell and fraction split
    t_hash w_cx, w_cy, w_cz;
    t_frac w_fx, w_fy, w_fz;

    assign w_cx = i_point_x[FRAC_BITS+7:FRAC_BITS];
    assign w_cy = i_point_y[FRAC_BITS+7:FRAC_BITS];
    assign w_cz = i_point_z[FRAC_BITS+7:FRAC_BITS];

    generate
        if (FRAC_BITS >= gn3_pkg::FRAC_W) begin : g_frac_trunc
            assign w_fx = i_point_x[FRAC_BITS-1:FRAC_BITS-gn3_pkg::FRAC_W];
            assign w_fy = i_point_y[FRAC_BITS-1:FRAC_BITS-gn3_pkg::FRAC_W];
            assign w_fz = i_point_z[FRAC_BITS-1:FRAC_BITS-gn3_pkg::FRAC_W];
        end else begin : g_frac_ext
            assign w_fx = {i_point_x[FRAC_BITS-1:0], (gn3_pkg::FRAC_W-FRAC_BITS)'(0)};
            assign w_fy = {i_point_y[FRAC_BITS-1:0], (gn3_pkg::FRAC_W-FRAC_BITS)'(0)};
            assign w_fz = {i_point_z[FRAC_BITS-1:0], (gn3_pkg::FRAC_W-FRAC_BITS)'(0)};
        end
    endgenerate

    // stage valids: evaluate words and load words
    logic r_ev1, r_ev2, r_ev3, r_ev4, r_ev5, r_ev6;
    logic r_wr1, r_wr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev1 <= 1'b0; r_ev2 <= 1'b0; r_ev3 <= 1'b0;
            r_ev4 <= 1'b0; r_ev5 <= 1'b0; r_ev6 <= 1'b0;
            r_wr1 <= 1'b0; r_wr2 <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_ev1 <= i_valid && i_op;
            r_wr1 <= i_valid && !i_op;
            r_ev2 <= r_ev1;
            r_wr2 <= r_wr1;
            r_ev3 <= r_ev2;
            r_ev4 <= r_ev3;
            r_ev5 <= r_ev4;
            r_ev6 <= r_ev5;
            r_ov  <= r_ev6;
        end
    end

    // stage 1 payload
    t_hash r_y1, r_z1, r_idx1, r_val1;
    t_frac r_fx1, r_fy1, r_fz1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y1   <= w_cy;
            r_z1   <= w_cz;
            r_idx1 <= i_table_index;
            r_val1 <= i_table_value;
            r_fx1  <= w_fx;
            r_fy1  <= w_fy;
            r_fz1  <= w_fz;
        end
    end

    // first lookup: perm(X), perm(X+1)
    t_hash w_px, w_px1;

    gn3_perm_ram u_ram_x (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_we      (w_acc && !i_op),
        .i_waddr   (i_table_index),
        .i_wdata   (i_table_value),
        .i_raddr_a (w_cx),
        .i_raddr_b (w_cx + 8'd1),
        .o_rdata_a (w_px),
        .o_rdata_b (w_px1)
    );

    // fade curves, result lands with stage 4
    t_fade w_u, w_v, w_w;

    gn3_fade u_fade_x (.i_clk(i_clk), .i_en(w_en), .i_t(r_fx1), .o_fade(w_u));
    gn3_fade u_fade_y (.i_clk(i_clk), .i_en(w_en), .i_t(r_fy1), .o_fade(w_v));
    gn3_fade u_fade_z (.i_clk(i_clk), .i_en(w_en), .i_t(r_fz1), .o_fade(w_w));

    // second lookup: A and B rows
    t_hash w_a, w_b;
    t_hash w_pa, w_pa1, w_pb, w_pb1;

    assign w_a = w_px + r_y1;
    assign w_b = w_px1 + r_y1;

    gn3_perm_ram u_ram_a (
        .i_clk(i_clk), .i_en(w_en), .i_we(w_en && r_wr1),
        .i_waddr(r_idx1), .i_wdata(r_val1),
        .i_raddr_a(w_a), .i_raddr_b(w_a + 8'd1),
        .o_rdata_a(w_pa), .o_rdata_b(w_pa1)
    );

    gn3_perm_ram u_ram_b (
        .i_clk(i_clk), .i_en(w_en), .i_we(w_en && r_wr1),
        .i_waddr(r_idx1), .i_wdata(r_val1),
        .i_raddr_a(w_b), .i_raddr_b(w_b + 8'd1),
        .o_rdata_a(w_pb), .o_rdata_b(w_pb1)
    );

    // stage 2 payload
    t_hash r_z2, r_idx2, r_val2;
    t_frac r_fx2, r_fy2, r_fz2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z2   <= r_z1;
            r_idx2 <= r_idx1;
            r_val2 <= r_val1;
            r_fx2  <= r_fx1;
            r_fy2  <= r_fy1;
            r_fz2  <= r_fz1;
        end
    end

    // third lookup: corner hashes
    t_hash w_aa, w_ab, w_ba, w_bb;
    t_hash w_h [8];

    assign w_aa = w_pa + r_z2;
    assign w_ab = w_pa1 + r_z2;
    assign w_ba = w_pb + r_z2;
    assign w_bb = w_pb1 + r_z2;

    gn3_perm_ram u_ram_aa (
        .i_clk(i_clk), .i_en(w_en), .i_we(w_en && r_wr2),
        .i_waddr(r_idx2), .i_wdata(r_val2),
        .i_raddr_a(w_aa), .i_raddr_b(w_aa + 8'd1),
        .o_rdata_a(w_h[0]), .o_rdata_b(w_h[4])
    );

    gn3_perm_ram u_ram_ba (
        .i_clk(i_clk), .i_en(w_en), .i_we(w_en && r_wr2),
        .i_waddr(r_idx2), .i_wdata(r_val2),
        .i_raddr_a(w_ba), .i_raddr_b(w_ba + 8'd1),
        .o_rdata_a(w_h[1]), .o_rdata_b(w_h[5])
    );

    gn3_perm_ram u_ram_ab (
        .i_clk(i_clk), .i_en(w_en), .i_we(w_en && r_wr2),
        .i_waddr(r_idx2), .i_wdata(r_val2),
        .i_raddr_a(w_ab), .i_raddr_b(w_ab + 8'd1),
        .o_rdata_a(w_h[2]), .o_rdata_b(w_h[6])
    );

    gn3_perm_ram u_ram_bb (
        .i_clk(i_clk), .i_en(w_en), .i_we(w_en && r_wr2),
        .i_waddr(r_idx2), .i_wdata(r_val2),
        .i_raddr_a(w_bb), .i_raddr_b(w_bb + 8'd1),
        .o_rdata_a(w_h[3]), .o_rdata_b(w_h[7])
    );

    // stage 3 payload
    t_frac r_fx3, r_fy3, r_fz3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fx3 <= r_fx2;
            r_fy3 <= r_fy2;
            r_fz3 <= r_fz2;
        end
    end

    // stage 4: corner gradients, corner k has far x/y/z in bits 0/1/2
    t_val r_g [8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 8; k++) begin
                r_g[k] <= grad(w_h[k], off(r_fx3, k[0]), off(r_fy3, k[1]),
                               off(r_fz3, k[2]));
            end
        end
    end

    // stage 5: blend along x
    t_val  r_l [4];
    t_fade r_v5, r_w5;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_l[k] <= lerp(w_u, r_g[2*k], r_g[2*k+1]);
            end
            r_v5 <= w_v;
            r_w5 <= w_w;
        end
    end

    // stage 6: blend along y
    t_val  r_m0, r_m1;
    t_fade r_w6;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0 <= lerp(r_v5, r_l[0], r_l[1]);
            r_m1 <= lerp(r_v5, r_l[2], r_l[3]);
            r_w6 <= r_w5;
        end
    end

    // stage 7: blend along z and saturate into the output register
    t_val w_r;
    logic signed [17:0] r_noise;

    assign w_r = lerp(r_w6, r_m0, r_m1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            priority if (w_r > gn3_pkg::OUT_MAX) begin
                r_noise <= gn3_pkg::OUT_MAX[17:0];
            end else if (w_r < gn3_pkg::OUT_MIN) begin
                r_noise <= gn3_pkg::OUT_MIN[17:0];
            end else begin
                r_noise <= w_r[17:0];
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_noise_value = r_noise;

    // a stalled pipeline keeps every stage valid in place
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({r_ev1, r_ev2, r_ev3, r_ev4, r_ev5, r_ev6, r_wr1, r_wr2}))
        else $error("pipeline moved during stall");

    // a stage never holds a load and a point at once
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ev1 && r_wr1) && !(r_ev2 && r_wr2))
        else $error("stage holds load and point together");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a new result enters only when a point left stage 6
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_ev6))
        else $error("result without point");

endmodule
